FILE: src/frt_pkg.sv
// shared constants, types and helpers of the call/return frame tracker
`timescale 1ns / 1ps

package frt_pkg;

    // table and stack sizes
    localparam int TBL_ENTRIES = 16;
    localparam int STK_DEPTH   = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam int TIDX_W = (TBL_ENTRIES > 1) ? $clog2(TBL_ENTRIES) : 1;
    localparam int SIDX_W = (STK_DEPTH > 1) ? $clog2(STK_DEPTH) : 1;
    localparam int OPEN_W = $clog2(STK_DEPTH + 1);
    localparam int QIDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // width of one instruction in bytes
    localparam logic [31:0] INSN_BYTES = 32'd4;

    // input command codes
    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_STEP = 2'd1,
        CMD_DROP = 2'd2
    } cmd_t;

    // result kinds
    typedef enum logic [1:0] {
        KIND_FRAME     = 2'd0,
        KIND_LOAD_OK   = 2'd1,
        KIND_LOAD_FULL = 2'd2,
        KIND_DROPPED   = 2'd3
    } kind_t;

    // classified operations handed from front to back
    typedef enum logic [1:0] {
        OP_LOAD_OK   = 2'd0,
        OP_LOAD_FULL = 2'd1,
        OP_STEP      = 2'd2,
        OP_DROP      = 2'd3
    } op_code_t;

    typedef struct packed {
        op_code_t    code;
        logic        hit;
        logic [31:0] addr;
        logic [31:0] stack_ptr;
        logic [31:0] link_reg;
        logic [31:0] exit_pc;
    } op_t;

    // queue status seen by front and back
    typedef struct packed {
        logic head_valid;
        logic full;
    } q_status_t;

    // back end states
    typedef enum logic {
        BS_RUN    = 1'b0,
        BS_UNWIND = 1'b1
    } back_state_t;

    // stack depth to the 5-bit result field
    function automatic logic [4:0] depth_field(input logic [OPEN_W-1:0] n);
        logic [OPEN_W+4:0] w;
        w = (OPEN_W + 5)'(n);
        return w[4:0];
    endfunction

endpackage

FILE: src/call_return_frame_tracker.sv
// top level of the call/return frame tracker
// load and dropped-push results pass the queue, then the result register; frame records wait
// in the held record; throughput: one item per cycle while the result port takes results;
// unwinding holds the back end; the frame stack, read at the top, pops one frame per cycle
// reset: synchronous, active low; clears table valid bits, open frames, sequence and queue
// no clearing pass: the block takes items in the first cycle after reset
`timescale 1ns / 1ps

module call_return_frame_tracker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [31:0] s_pc,
    input  logic [31:0] s_stack_ptr,
    input  logic [31:0] s_link_reg,
    input  logic [31:0] s_entry_va,
    input  logic [31:0] s_entry_size,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [63:0] m_seq,
    output logic [31:0] m_func_va,
    output logic [31:0] m_caller_addr,
    output logic [31:0] m_step_count,
    output logic [4:0]  m_depth,
    output logic        m_last
);

    frt_pkg::q_status_t q_status;
    frt_pkg::op_t       wr_op, rd_op;
    logic               q_push, q_pop;

    // classification and traced entry table
    frt_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_pc         (s_pc),
        .s_stack_ptr  (s_stack_ptr),
        .s_link_reg   (s_link_reg),
        .s_entry_va   (s_entry_va),
        .s_entry_size (s_entry_size),
        .q_status     (q_status),
        .q_push       (q_push),
        .q_op         (wr_op)
    );

    // decoupling queue
    frt_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_op   (wr_op),
        .pop     (q_pop),
        .rd_op   (rd_op),
        .status  (q_status)
    );

    // frame stack and result channel
    frt_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_status      (q_status),
        .op            (rd_op),
        .op_pop        (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_seq         (m_seq),
        .m_func_va     (m_func_va),
        .m_caller_addr (m_caller_addr),
        .m_step_count  (m_step_count),
        .m_depth       (m_depth),
        .m_last        (m_last)
    );

endmodule

FILE: src/frt_queue.sv
// short operation queue between the front and back ends
`timescale 1ns / 1ps

module frt_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  frt_pkg::op_t      wr_op,
    input  logic              pop,
    output frt_pkg::op_t      rd_op,
    output frt_pkg::q_status_t status
);

    frt_pkg::op_t                mem [frt_pkg::QUEUE_DEPTH];
    logic [frt_pkg::QIDX_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [frt_pkg::QIDX_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [frt_pkg::QCNT_W-1:0]  cnt_reg, cnt_next;
    logic                        do_push, do_pop;

    // pointer and fill count update
    always_comb begin
        do_push = push && (cnt_reg != frt_pkg::QCNT_W'(frt_pkg::QUEUE_DEPTH));
        do_pop  = pop && (cnt_reg != '0);
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == frt_pkg::QIDX_W'(frt_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == frt_pkg::QIDX_W'(frt_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= wr_op;
        end
    end

    // head and status
    assign rd_op             = mem[rd_ptr_reg];
    assign status.head_valid = (cnt_reg != '0);
    assign status.full       = (cnt_reg == frt_pkg::QCNT_W'(frt_pkg::QUEUE_DEPTH));

    // fill count stays in range
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= frt_pkg::QCNT_W'(frt_pkg::QUEUE_DEPTH))
        else $error("queue fill count out of range");

    // no write is offered to a full queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        status.full |-> !push)
        else $error("push into full queue");

    // no read is taken from an empty queue
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !status.head_valid |-> !pop)
        else $error("pop from empty queue");

endmodule

FILE: src/frt_front.sv
// front end: accepts items, keeps the traced entry table and classifies each item
`timescale 1ns / 1ps

module frt_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_cmd,
    input  logic [31:0]        s_pc,
    input  logic [31:0]        s_stack_ptr,
    input  logic [31:0]        s_link_reg,
    input  logic [31:0]        s_entry_va,
    input  logic [31:0]        s_entry_size,
    input  frt_pkg::q_status_t q_status,
    output logic               q_push,
    output frt_pkg::op_t       q_op
);

    logic                        ent_valid_reg [frt_pkg::TBL_ENTRIES];
    logic [31:0]                 ent_addr_reg  [frt_pkg::TBL_ENTRIES];
    logic [31:0]                 ent_len_reg   [frt_pkg::TBL_ENTRIES];

    logic                        accept;
    logic [31:0]                 key;
    logic                        match_any, free_any;
    logic [frt_pkg::TIDX_W-1:0]  match_idx, free_idx, wr_idx;
    logic [31:0]                 hit_len;
    logic                        tbl_wr;

    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;

    // parallel match against the table, lowest slot wins
    always_comb begin
        key       = (s_cmd == frt_pkg::CMD_LOAD) ? s_entry_va : s_pc;
        match_any = 1'b0;
        free_any  = 1'b0;
        match_idx = '0;
        free_idx  = '0;
        for (int i = frt_pkg::TBL_ENTRIES - 1; i >= 0; i--) begin
            if (ent_valid_reg[i] && (ent_addr_reg[i] == key)) begin
                match_any = 1'b1;
                match_idx = frt_pkg::TIDX_W'(i);
            end
            if (!ent_valid_reg[i]) begin
                free_any = 1'b1;
                free_idx = frt_pkg::TIDX_W'(i);
            end
        end
    end

    assign wr_idx  = match_any ? match_idx : free_idx;
    assign hit_len = ent_len_reg[match_idx];

    // classify the item into a queue operation
    always_comb begin
        q_push          = 1'b0;
        tbl_wr          = 1'b0;
        q_op.code       = frt_pkg::OP_STEP;
        q_op.hit        = match_any;
        q_op.addr       = key;
        q_op.stack_ptr  = s_stack_ptr;
        q_op.link_reg   = s_link_reg;
        q_op.exit_pc    = (hit_len >= frt_pkg::INSN_BYTES) ?
                          (s_pc + hit_len - frt_pkg::INSN_BYTES) : '0;
        case (s_cmd)
            frt_pkg::CMD_LOAD: begin
                q_push    = accept;
                tbl_wr    = accept && (match_any || free_any);
                q_op.code = (match_any || free_any) ? frt_pkg::OP_LOAD_OK :
                                                      frt_pkg::OP_LOAD_FULL;
            end
            frt_pkg::CMD_STEP: begin
                q_push    = accept;
                q_op.code = frt_pkg::OP_STEP;
            end
            frt_pkg::CMD_DROP: begin
                q_push    = accept;
                q_op.code = frt_pkg::OP_DROP;
            end
            default: begin
                q_push = 1'b0;
            end
        endcase
    end

    // table valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < frt_pkg::TBL_ENTRIES; i++) begin
                ent_valid_reg[i] <= 1'b0;
            end
        end else if (tbl_wr) begin
            ent_valid_reg[wr_idx] <= 1'b1;
        end
    end

    // table address and size
    always_ff @(posedge aclk) begin
        if (tbl_wr) begin
            ent_addr_reg[wr_idx] <= s_entry_va;
            ent_len_reg[wr_idx]  <= s_entry_size;
        end
    end

endmodule

FILE: src/frt_back.sv
// back end: shadow frame stack, unwind sequencing and result register
`timescale 1ns / 1ps

module frt_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  frt_pkg::q_status_t  q_status,
    input  frt_pkg::op_t        op,
    output logic                op_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_kind,
    output logic [63:0]         m_seq,
    output logic [31:0]         m_func_va,
    output logic [31:0]         m_caller_addr,
    output logic [31:0]         m_step_count,
    output logic [4:0]          m_depth,
    output logic                m_last
);

    // frame stack
    logic [31:0] fr_func  [frt_pkg::STK_DEPTH];
    logic [31:0] fr_ret   [frt_pkg::STK_DEPTH];
    logic [31:0] fr_sp    [frt_pkg::STK_DEPTH];
    logic [31:0] fr_exit  [frt_pkg::STK_DEPTH];
    logic [31:0] fr_count [frt_pkg::STK_DEPTH];

    frt_pkg::back_state_t        st_reg, st_next;
    logic [frt_pkg::OPEN_W-1:0]  open_reg, open_next;
    logic [63:0]                 seq_reg, seq_next;

    // popped record waiting until its last flag is known
    logic [31:0]                 pend_func_reg, pend_func_next;
    logic [31:0]                 pend_caller_reg, pend_caller_next;
    logic [31:0]                 pend_count_reg, pend_count_next;
    logic [frt_pkg::OPEN_W-1:0]  pend_depth_reg, pend_depth_next;
    logic [63:0]                 pend_seq_reg, pend_seq_next;

    // result register
    logic                        m_valid_reg, m_valid_next;
    frt_pkg::kind_t              m_kind_reg, m_kind_next;
    logic [63:0]                 m_seq_reg, m_seq_next;
    logic [31:0]                 m_func_reg, m_func_next;
    logic [31:0]                 m_caller_reg, m_caller_next;
    logic [31:0]                 m_count_reg, m_count_next;
    logic [4:0]                  m_depth_reg, m_depth_next;
    logic                        m_last_reg, m_last_next;

    logic [frt_pkg::SIDX_W-1:0]  top_idx, push_idx, cnt_idx;
    logic                        stk_empty, stk_full, is_ret, out_free, need_out;
    logic                        push_en, cnt_en;
    logic [31:0]                 cnt_val;

    // top of stack and return test
    always_comb begin
        top_idx   = frt_pkg::SIDX_W'(open_reg - 1'b1);
        push_idx  = frt_pkg::SIDX_W'(open_reg);
        stk_empty = (open_reg == '0);
        stk_full  = (open_reg == frt_pkg::OPEN_W'(frt_pkg::STK_DEPTH));
        is_ret    = !stk_empty &&
                    (((fr_ret[top_idx] != '0) && (op.addr == fr_ret[top_idx]) &&
                      (op.stack_ptr >= fr_sp[top_idx])) ||
                     ((fr_exit[top_idx] != '0) && (op.addr == fr_exit[top_idx])));
        out_free  = !m_valid_reg || m_ready;
    end

    // next state, stack updates and result selection
    always_comb begin
        st_next          = st_reg;
        open_next        = open_reg;
        seq_next         = seq_reg;
        pend_func_next   = pend_func_reg;
        pend_caller_next = pend_caller_reg;
        pend_count_next  = pend_count_reg;
        pend_depth_next  = pend_depth_reg;
        pend_seq_next    = pend_seq_reg;
        op_pop           = 1'b0;
        push_en          = 1'b0;
        cnt_en           = 1'b0;
        cnt_idx          = top_idx;
        cnt_val          = fr_count[top_idx] + 32'd1;
        need_out         = 1'b0;

        m_valid_next  = m_valid_reg && !m_ready;
        m_kind_next   = m_kind_reg;
        m_seq_next    = m_seq_reg;
        m_func_next   = m_func_reg;
        m_caller_next = m_caller_reg;
        m_count_next  = m_count_reg;
        m_depth_next  = m_depth_reg;
        m_last_next   = m_last_reg;

        if (q_status.head_valid) begin
            case (op.code)
                frt_pkg::OP_LOAD_OK, frt_pkg::OP_LOAD_FULL: begin
                    if (out_free) begin
                        op_pop        = 1'b1;
                        m_valid_next  = 1'b1;
                        m_kind_next   = (op.code == frt_pkg::OP_LOAD_OK) ?
                                        frt_pkg::KIND_LOAD_OK : frt_pkg::KIND_LOAD_FULL;
                        m_seq_next    = seq_reg;
                        m_func_next   = op.addr;
                        m_caller_next = '0;
                        m_count_next  = '0;
                        m_depth_next  = frt_pkg::depth_field(open_reg);
                        m_last_next   = 1'b1;
                    end
                end
                frt_pkg::OP_DROP: begin
                    op_pop    = 1'b1;
                    open_next = '0;
                end
                frt_pkg::OP_STEP: begin
                    if (is_ret) begin
                        // pop one frame, send the one popped before it
                        need_out = (st_reg == frt_pkg::BS_UNWIND);
                        if (!need_out || out_free) begin
                            if (need_out) begin
                                m_valid_next  = 1'b1;
                                m_kind_next   = frt_pkg::KIND_FRAME;
                                m_seq_next    = pend_seq_reg;
                                m_func_next   = pend_func_reg;
                                m_caller_next = pend_caller_reg;
                                m_count_next  = pend_count_reg;
                                m_depth_next  = frt_pkg::depth_field(pend_depth_reg);
                                m_last_next   = 1'b0;
                            end
                            pend_func_next   = fr_func[top_idx];
                            pend_caller_next = fr_ret[top_idx] - frt_pkg::INSN_BYTES;
                            pend_count_next  = fr_count[top_idx];
                            pend_depth_next  = open_reg - 1'b1;
                            pend_seq_next    = seq_reg;
                            open_next        = open_reg - 1'b1;
                            seq_next         = seq_reg + 64'd1;
                            st_next          = frt_pkg::BS_UNWIND;
                        end
                    end else begin
                        // unwinding done: push, count and finish the item
                        need_out = (st_reg == frt_pkg::BS_UNWIND) || (op.hit && stk_full);
                        if (!need_out || out_free) begin
                            op_pop  = 1'b1;
                            st_next = frt_pkg::BS_RUN;
                            if (st_reg == frt_pkg::BS_UNWIND) begin
                                m_valid_next  = 1'b1;
                                m_kind_next   = frt_pkg::KIND_FRAME;
                                m_seq_next    = pend_seq_reg;
                                m_func_next   = pend_func_reg;
                                m_caller_next = pend_caller_reg;
                                m_count_next  = pend_count_reg;
                                m_depth_next  = frt_pkg::depth_field(pend_depth_reg);
                                m_last_next   = 1'b1;
                            end else if (op.hit && stk_full) begin
                                m_valid_next  = 1'b1;
                                m_kind_next   = frt_pkg::KIND_DROPPED;
                                m_seq_next    = seq_reg;
                                m_func_next   = op.addr;
                                m_caller_next = op.link_reg - frt_pkg::INSN_BYTES;
                                m_count_next  = '0;
                                m_depth_next  = frt_pkg::depth_field(open_reg);
                                m_last_next   = 1'b1;
                            end
                            if (op.hit && !stk_full) begin
                                push_en   = 1'b1;
                                open_next = open_reg + 1'b1;
                                cnt_en    = 1'b1;
                                cnt_idx   = push_idx;
                                cnt_val   = 32'd1;
                            end else if (!stk_empty) begin
                                cnt_en = 1'b1;
                            end
                        end
                    end
                end
                default: begin
                    op_pop = 1'b1;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= frt_pkg::BS_RUN;
            open_reg    <= '0;
            seq_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            st_reg      <= st_next;
            open_reg    <= open_next;
            seq_reg     <= seq_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        pend_func_reg   <= pend_func_next;
        pend_caller_reg <= pend_caller_next;
        pend_count_reg  <= pend_count_next;
        pend_depth_reg  <= pend_depth_next;
        pend_seq_reg    <= pend_seq_next;
        m_kind_reg      <= m_kind_next;
        m_seq_reg       <= m_seq_next;
        m_func_reg      <= m_func_next;
        m_caller_reg    <= m_caller_next;
        m_count_reg     <= m_count_next;
        m_depth_reg     <= m_depth_next;
        m_last_reg      <= m_last_next;
    end

    // frame stack writes
    always_ff @(posedge aclk) begin
        if (push_en) begin
            fr_func[push_idx] <= op.addr;
            fr_ret[push_idx]  <= op.link_reg;
            fr_sp[push_idx]   <= op.stack_ptr;
            fr_exit[push_idx] <= op.exit_pc;
        end
        if (cnt_en) begin
            fr_count[cnt_idx] <= cnt_val;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_kind        = m_kind_reg;
    assign m_seq         = m_seq_reg;
    assign m_func_va     = m_func_reg;
    assign m_caller_addr = m_caller_reg;
    assign m_step_count  = m_count_reg;
    assign m_depth       = m_depth_reg;
    assign m_last        = m_last_reg;

    // stack depth never passes its capacity
    a_open_range: assert property (@(posedge aclk) disable iff (!aresetn)
        open_reg <= frt_pkg::OPEN_W'(frt_pkg::STK_DEPTH))
        else $error("open frame count out of range");

    // a held record belongs to a step still at the queue head
    a_unwind_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == frt_pkg::BS_UNWIND) |->
        (q_status.head_valid && (op.code == frt_pkg::OP_STEP)))
        else $error("unwind without a pending step");

    // held record depth tracks the stack
    a_unwind_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == frt_pkg::BS_UNWIND) |-> (open_reg == pend_depth_reg))
        else $error("held record depth mismatch");

    // sequence advances only while popping
    a_seq_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (seq_next != seq_reg) |-> (st_next == frt_pkg::BS_UNWIND))
        else $error("sequence moved without a pop");

endmodule

FILE: test/tb.sv
// testbench for the call/return frame tracker: shadow stack prediction under randomized traffic
`timescale 1ns / 1ps

module tb;

    // the block ignores the fourth command code
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int N_RANDOM     = 100;
    localparam int CALM_TAIL    = 30;
    localparam int POOL_SIZE    = 24;
    localparam int GEN_STACK    = 32;
    localparam int HANG_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 10;

    typedef struct {
        logic [1:0]  cmd;
        logic [31:0] pc, sp, lr, va, size;
    } instr_item_t;

    typedef struct {
        frt_pkg::kind_t kind;
        logic [63:0]    seq;
        logic [31:0]    func_va, caller_addr, step_count;
        logic [4:0]     depth;
        logic           last;
    } frame_rec_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_cmd = frt_pkg::CMD_STEP;
    logic [31:0] s_pc = '0;
    logic [31:0] s_stack_ptr = '0;
    logic [31:0] s_link_reg = '0;
    logic [31:0] s_entry_va = '0;
    logic [31:0] s_entry_size = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_kind;
    logic [63:0] m_seq;
    logic [31:0] m_func_va;
    logic [31:0] m_caller_addr;
    logic [31:0] m_step_count;
    logic [4:0]  m_depth;
    logic        m_last;

    call_return_frame_tracker dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_pc          (s_pc),
        .s_stack_ptr   (s_stack_ptr),
        .s_link_reg    (s_link_reg),
        .s_entry_va    (s_entry_va),
        .s_entry_size  (s_entry_size),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_seq         (m_seq),
        .m_func_va     (m_func_va),
        .m_caller_addr (m_caller_addr),
        .m_step_count  (m_step_count),
        .m_depth       (m_depth),
        .m_last        (m_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predicted table of traced entries and shadow stack of open frames
    logic        tbl_valid [frt_pkg::TBL_ENTRIES] = '{default: 1'b0};
    logic [31:0] tbl_addr  [frt_pkg::TBL_ENTRIES];
    logic [31:0] tbl_len   [frt_pkg::TBL_ENTRIES];
    logic [31:0] stk_func  [frt_pkg::STK_DEPTH];
    logic [31:0] stk_ret   [frt_pkg::STK_DEPTH];
    logic [31:0] stk_sp    [frt_pkg::STK_DEPTH];
    logic [31:0] stk_exit  [frt_pkg::STK_DEPTH];
    logic [31:0] stk_cnt   [frt_pkg::STK_DEPTH];
    int          stk_open = 0;
    logic [63:0] rec_seq = '0;

    instr_item_t instr_feed [$];
    frame_rec_t  records_due [$];

    int n_fed = 0;
    int n_checked = 0;
    int n_pops = 0;
    int n_push_dropped = 0;
    int n_load_full = 0;
    int mismatches = 0;
    int feed_gap = 0;
    int sink_gap = 0;
    int hang_cycles = 0;
    logic in_fire = 1'b0;
    instr_item_t drv_item;
    instr_item_t mon_item;
    frame_rec_t  want;

    // stimulus generator: function pool and a rough model of the program's call stack
    logic [31:0] pool_va  [POOL_SIZE];
    logic [31:0] pool_len [POOL_SIZE];
    logic [31:0] g_func [GEN_STACK];
    logic [31:0] g_ret  [GEN_STACK];
    logic [31:0] g_sp   [GEN_STACK];
    logic [31:0] g_exit [GEN_STACK];
    int          g_depth = 0;
    logic [31:0] gen_sp = 32'h8000_0000;

    function automatic frame_rec_t make_rec(frt_pkg::kind_t kind, logic [31:0] func_va,
                                            logic [31:0] caller_addr,
                                            logic [31:0] step_count);
        frame_rec_t r;
        r.kind        = kind;
        r.seq         = rec_seq;
        r.func_va     = func_va;
        r.caller_addr = caller_addr;
        r.step_count  = step_count;
        r.depth       = 5'(stk_open);
        r.last        = 1'b0;
        return r;
    endfunction

    // works out the records one accepted transfer causes and queues them
    function automatic void shadow_stack_step(instr_item_t it);
        frame_rec_t  out_recs [frt_pkg::STK_DEPTH + 2];
        int          n, slot, hit, t;
        logic        unwinding;
        logic [31:0] len;
        n = 0;
        slot = -1;
        hit = -1;
        if (it.cmd == frt_pkg::CMD_LOAD) begin
            // same address first, then the lowest free slot
            for (int i = 0; i < frt_pkg::TBL_ENTRIES; i++)
                if (slot < 0 && tbl_valid[i] && tbl_addr[i] == it.va) slot = i;
            for (int i = 0; i < frt_pkg::TBL_ENTRIES; i++)
                if (slot < 0 && !tbl_valid[i]) slot = i;
            if (slot < 0) begin
                out_recs[n] = make_rec(frt_pkg::KIND_LOAD_FULL, it.va, '0, '0);
                n_load_full++;
            end else begin
                tbl_valid[slot] = 1'b1;
                tbl_addr[slot]  = it.va;
                tbl_len[slot]   = it.size;
                out_recs[n] = make_rec(frt_pkg::KIND_LOAD_OK, it.va, '0, '0);
            end
            n++;
        end else if (it.cmd == frt_pkg::CMD_DROP) begin
            stk_open = 0;
        end else if (it.cmd == frt_pkg::CMD_STEP) begin
            // pop every returned innermost frame
            unwinding = 1'b1;
            while (unwinding && stk_open > 0) begin
                t = stk_open - 1;
                if ((stk_ret[t] != '0 && it.pc == stk_ret[t] && it.sp >= stk_sp[t]) ||
                    (stk_exit[t] != '0 && it.pc == stk_exit[t])) begin
                    stk_open = t;
                    out_recs[n] = make_rec(frt_pkg::KIND_FRAME, stk_func[t],
                                           stk_ret[t] - frt_pkg::INSN_BYTES, stk_cnt[t]);
                    n++;
                    rec_seq++;
                    n_pops++;
                end else begin
                    unwinding = 1'b0;
                end
            end
            // open a frame on a traced entry
            for (int i = 0; i < frt_pkg::TBL_ENTRIES; i++)
                if (hit < 0 && tbl_valid[i] && tbl_addr[i] == it.pc) hit = i;
            if (hit >= 0) begin
                if (stk_open >= frt_pkg::STK_DEPTH) begin
                    out_recs[n] = make_rec(frt_pkg::KIND_DROPPED, it.pc,
                                           it.lr - frt_pkg::INSN_BYTES, '0);
                    n++;
                    n_push_dropped++;
                end else begin
                    len = tbl_len[hit];
                    stk_func[stk_open] = it.pc;
                    stk_ret[stk_open]  = it.lr;
                    stk_sp[stk_open]   = it.sp;
                    stk_exit[stk_open] = (len >= frt_pkg::INSN_BYTES) ?
                                         it.pc + len - frt_pkg::INSN_BYTES : '0;
                    stk_cnt[stk_open]  = '0;
                    stk_open++;
                end
            end
            // the step counts against the innermost frame
            if (stk_open > 0) stk_cnt[stk_open - 1] = stk_cnt[stk_open - 1] + 32'd1;
        end
        if (n > 0) out_recs[n - 1].last = 1'b1;
        for (int i = 0; i < n; i++) records_due = {records_due, out_recs[i]};
    endfunction

    function automatic void check_field(string name, logic [63:0] want_v, logic [63:0] got_v);
        if (want_v !== got_v) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want_v, got_v);
            mismatches++;
        end
    endfunction

    function automatic void add_item(logic [1:0] cmd, logic [31:0] pc, logic [31:0] sp,
                                     logic [31:0] lr, logic [31:0] va, logic [31:0] size);
        instr_item_t it;
        it.cmd = cmd;
        it.pc = pc;
        it.sp = sp;
        it.lr = lr;
        it.va = va;
        it.size = size;
        instr_feed = {instr_feed, it};
        if (cmd != CMD_UNUSED) n_fed++;
    endfunction

    // deep recursion of the first pool function, enough to overflow the stack, then its exit
    function automatic void gen_recursion();
        int calls;
        calls = $urandom_range(17, 20);
        for (int i = 0; i < calls; i++) begin
            gen_sp = gen_sp - 32'h40;
            add_item(frt_pkg::CMD_STEP, pool_va[0], gen_sp, $urandom & 32'hFFFF_FFFC,
                     $urandom, $urandom);
        end
        add_item(frt_pkg::CMD_STEP, pool_va[0] + pool_len[0] - frt_pkg::INSN_BYTES,
                 $urandom, $urandom, $urandom, $urandom);
        g_depth = 0;
    endfunction

    // driver: one item held on the port until its transfer, random gaps between items
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || in_fire) begin
                if (feed_gap > 0) begin
                    feed_gap = feed_gap - 1;
                    s_valid <= 1'b0;
                end else if (instr_feed.size() > 0) begin
                    drv_item = instr_feed.pop_front();
                    s_cmd        <= drv_item.cmd;
                    s_pc         <= drv_item.pc;
                    s_stack_ptr  <= drv_item.sp;
                    s_link_reg   <= drv_item.lr;
                    s_entry_va   <= drv_item.va;
                    s_entry_size <= drv_item.size;
                    s_valid      <= 1'b1;
                    if (instr_feed.size() >= CALM_TAIL && $urandom_range(0, 4) == 0)
                        feed_gap = $urandom_range(1, 17);
                end else begin
                    s_valid <= 1'b0;
                end
            end
            // receiver stalls in bursts
            if (sink_gap > 0) begin
                sink_gap = sink_gap - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (instr_feed.size() >= CALM_TAIL && $urandom_range(0, 5) == 0)
                    sink_gap = $urandom_range(1, 17);
            end
        end
    end

    // monitor: predict on input transfers, check output transfers, watch for a hang
    always @(posedge aclk) begin
        in_fire = aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (in_fire) begin
                mon_item.cmd  = s_cmd;
                mon_item.pc   = s_pc;
                mon_item.sp   = s_stack_ptr;
                mon_item.lr   = s_link_reg;
                mon_item.va   = s_entry_va;
                mon_item.size = s_entry_size;
                shadow_stack_step(mon_item);
            end
            if (m_valid && m_ready) begin
                if (records_due.size() == 0) begin
                    $error("unexpected result: kind %0d seq %0d func 0x%0h",
                           m_kind, m_seq, m_func_va);
                    mismatches++;
                end else begin
                    want = records_due.pop_front();
                    check_field("kind", 64'(want.kind), 64'(m_kind));
                    check_field("seq", want.seq, m_seq);
                    check_field("func_va", 64'(want.func_va), 64'(m_func_va));
                    check_field("caller_addr", 64'(want.caller_addr), 64'(m_caller_addr));
                    check_field("step_count", 64'(want.step_count), 64'(m_step_count));
                    check_field("depth", 64'(want.depth), 64'(m_depth));
                    check_field("last", 64'(want.last), 64'(m_last));
                    n_checked++;
                end
            end
            if (in_fire || (m_valid && m_ready)) hang_cycles = 0;
            else hang_cycles++;
            if (hang_cycles >= HANG_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", HANG_LIMIT);
                $display("call_return_frame_tracker test failed");
                $finish;
            end
        end
    end

    initial begin
        int n_directed;
        int roll, act, k, t;
        logic pool_loaded;
        logic [31:0] pc, sp, lr;

        // function pool; the first one is also used by the directed part
        pool_va[0]  = 32'h0000_1000;
        pool_len[0] = 32'h80;
        for (int i = 1; i < POOL_SIZE; i++) begin
            pool_va[i]  = $urandom & 32'hFFFF_FFFC;
            pool_len[i] = (i % 5 == 0) ? 32'($urandom_range(0, 3)) :
                                         32'(4 * $urandom_range(1, 255));
        end

        // directed part
        add_item(frt_pkg::CMD_STEP, '0, '0, '0, '0, '0);                // empty stack, no entries
        add_item(frt_pkg::CMD_LOAD, '0, '0, '0, 32'h0000_1000, 32'h40);
        add_item(frt_pkg::CMD_LOAD, '0, '0, '0, 32'h0000_2000, 32'h0); // unknown size
        add_item(frt_pkg::CMD_LOAD, '0, '0, '0, 32'hFFFF_FFFC, 32'hFFFF_FFFF); // exit wraps
        add_item(frt_pkg::CMD_LOAD, '0, '0, '0, 32'h0000_1000, 32'h80); // reload known address
        add_item(frt_pkg::CMD_STEP, 32'h1000, 32'h8000, 32'h3004, '0, '0);  // call A
        add_item(frt_pkg::CMD_STEP, 32'h1004, 32'h8000, 32'h3004, '0, '0);
        add_item(frt_pkg::CMD_STEP, 32'h2000, 32'h7F00, 32'h1008, '0, '0);  // call B
        add_item(frt_pkg::CMD_STEP, 32'h1008, 32'h7E00, '0, '0, '0);  // sp below entry sp
        add_item(frt_pkg::CMD_STEP, 32'h1008, 32'h7F00, '0, '0, '0);  // B returns via link
        add_item(frt_pkg::CMD_STEP, 32'h107C, '0, '0, '0, '0);        // A leaves at fixed exit
        add_item(frt_pkg::CMD_STEP, 32'hFFFF_FFFC, 32'hFFFF_FFFF, '0, '0, '0); // zero link
        add_item(frt_pkg::CMD_STEP, '0, 32'hFFFF_FFFF, '0, '0, '0);   // zero return never matches
        add_item(frt_pkg::CMD_STEP, 32'h2000, 32'h100, '0, '0, '0);
        add_item(frt_pkg::CMD_STEP, 32'h1000, 32'h80, 32'h2010, '0, '0);
        add_item(frt_pkg::CMD_STEP, 32'h1000, 32'h40, 32'h2010, '0, '0);    // recursion
        add_item(frt_pkg::CMD_STEP, 32'h107C, '0, '0, '0, '0);        // two frames unwind at once
        add_item(frt_pkg::CMD_DROP, '0, '0, '0, '0, '0);
        add_item(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_item(frt_pkg::CMD_STEP, 32'h1000, '0, 32'h2000, '0, '0);
        add_item(frt_pkg::CMD_STEP, 32'h2000, '0, 32'hFFFF_FFFF, '0, '0); // pop then push
        add_item(frt_pkg::CMD_STEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, '0);
        n_directed = n_fed;

        // random part: mostly well-formed call/return traffic
        gen_recursion();
        pool_loaded = 1'b0;
        while (n_fed < n_directed + N_RANDOM) begin
            // halfway through, load the whole pool so the table overflows
            if (!pool_loaded && n_fed >= n_directed + N_RANDOM / 2) begin
                pool_loaded = 1'b1;
                for (int i = 0; i < POOL_SIZE; i++)
                    add_item(frt_pkg::CMD_LOAD, $urandom, $urandom, $urandom,
                             pool_va[i], pool_len[i]);
            end
            roll = $urandom_range(0, 99);
            if (roll < 12) begin
                if ($urandom_range(0, 2) != 0) begin
                    k = $urandom_range(0, POOL_SIZE - 1);
                    add_item(frt_pkg::CMD_LOAD, $urandom, $urandom, $urandom,
                             pool_va[k], pool_len[k]);
                end else begin
                    add_item(frt_pkg::CMD_LOAD, $urandom, $urandom, $urandom,
                             $urandom, $urandom);
                end
            end else if (roll < 15) begin
                add_item(frt_pkg::CMD_DROP, $urandom, $urandom, $urandom, $urandom, $urandom);
                g_depth = 0;
            end else if (roll < 17) begin
                add_item(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom);
            end else if (roll < 20) begin
                gen_recursion();
            end else if (roll < 27) begin
                add_item(frt_pkg::CMD_STEP, $urandom, $urandom, $urandom, $urandom, $urandom);
            end else begin
                act = $urandom_range(0, 9);
                if (g_depth >= GEN_STACK || (g_depth > 0 && act < 4)) begin
                    // return from the innermost frame
                    t = g_depth - 1;
                    k = $urandom_range(0, 5);
                    if (k == 0 && g_exit[t] != '0) begin
                        pc = g_exit[t];
                        sp = gen_sp;
                        g_depth--;
                        gen_sp = g_sp[t];
                    end else if (k == 1 && g_sp[t] != '0) begin
                        pc = g_ret[t];
                        sp = g_sp[t] - 32'd1;
                    end else begin
                        pc = g_ret[t];
                        sp = g_sp[t] + 32'($urandom_range(0, 32));
                        g_depth--;
                        gen_sp = g_sp[t];
                    end
                    add_item(frt_pkg::CMD_STEP, pc, sp, $urandom, $urandom, $urandom);
                end else if (act < 7) begin
                    // call a pool function
                    k = $urandom_range(0, POOL_SIZE - 1);
                    lr = ($urandom_range(0, 19) == 0) ? 32'd0 : ($urandom & 32'hFFFF_FFFC);
                    gen_sp = gen_sp - 32'(16 * $urandom_range(1, 32));
                    add_item(frt_pkg::CMD_STEP, pool_va[k], gen_sp, lr, $urandom, $urandom);
                    g_func[g_depth] = pool_va[k];
                    g_ret[g_depth]  = lr;
                    g_sp[g_depth]   = gen_sp;
                    g_exit[g_depth] = (pool_len[k] >= frt_pkg::INSN_BYTES) ?
                                      pool_va[k] + pool_len[k] - frt_pkg::INSN_BYTES : '0;
                    g_depth++;
                end else begin
                    // ordinary instruction in the current function
                    pc = (g_depth > 0) ? g_func[g_depth - 1] + 32'(4 * $urandom_range(1, 6))
                                       : $urandom;
                    add_item(frt_pkg::CMD_STEP, pc, gen_sp, $urandom, $urandom, $urandom);
                end
            end
        end

        // reset, then let the driver and monitor run
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (instr_feed.size() != 0 || s_valid || records_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (records_due.size() != 0) begin
            $error("%0d expected results never arrived", records_due.size());
            mismatches++;
        end

        $display("covered %0d items and %0d checked results: %0d frames unwound,",
                 n_fed, n_checked, n_pops);
        $display("%0d pushes dropped on a full stack, %0d loads refused on a full table",
                 n_push_dropped, n_load_full);
        if (mismatches == 0) begin
            $display("call_return_frame_tracker test passed");
        end else begin
            $display("call_return_frame_tracker test failed");
        end
        $finish;
    end

endmodule
